// ===== sv/lpfd_pkg.sv =====
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; the top level, the parser and the output register import this package.
package lpfd_pkg;

  // Result status codes.
  localparam logic [1:0] ST_PAYLOAD = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_BADSIZE = 2'd2;

  // Parser phase codes.
  localparam logic [2:0] PH_SIZE_HI = 3'd0;
  localparam logic [2:0] PH_SIZE_LO = 3'd1;
  localparam logic [2:0] PH_OP_LO   = 3'd2;
  localparam logic [2:0] PH_OP_HI   = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // Bytes of the body taken by the opcode.
  localparam logic [15:0] OPCODE_BYTES = 16'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] frame_opcode;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
    logic        first_of_frame;
    logic        last_of_frame;
  } res_t;

endpackage

// ===== sv/length_prefixed_frame_deframer.sv =====
// Length-prefixed frame deframer. Takes a received byte stream, one byte per
// transfer, and splits it into frames made of a big-endian 16-bit body size, a
// little-endian 16-bit opcode and body size minus two payload bytes. Every
// payload byte leaves as one result transfer carrying the opcode, the payload
// length and first/last marks; a frame with no payload gives a single
// empty-frame result when its opcode completes, and the size and low opcode
// bytes give no result. A body size below two gives one invalid-size result,
// after which every byte is accepted and dropped until reset. The block takes
// one byte per clock cycle while the output side does not hold it back; the
// parser sits between the input register and the output register. An accepted
// byte waits in the input register, its result is registered in the output
// register and waits there while stall is high, with the input side held only
// once that register is full and the next byte would produce a result.
// Depends on lpfd_pkg, lpfd_in_reg, lpfd_parser and lpfd_out_reg.
module length_prefixed_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_frame_opcode,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_length,
  output logic        out_first_of_frame,
  output logic        out_last_of_frame
);
  import lpfd_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       consume;
  logic       emit;
  logic       out_free;
  res_t       res;

  // Input register: one byte waits here while the parser looks at it.
  lpfd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .consume    (consume),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  // Parser: header tracking and the result for the held byte.
  lpfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .out_free   (out_free),
    .consume    (consume),
    .emit       (emit),
    .res        (res)
  );

  // Output register: decouples the result side from the input side.
  lpfd_out_reg u_out_reg (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (emit),
    .res                (res),
    .out_free           (out_free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_frame_opcode   (out_frame_opcode),
    .out_payload_byte   (out_payload_byte),
    .out_payload_length (out_payload_length),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame)
  );

endmodule

// ===== sv/lpfd_in_reg.sv =====
// Input register stage of the deframer: holds one received byte.
// Depends on nothing but the consume strobe from the parser.
module lpfd_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       consume,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic [7:0] byte_r;

  // The register can take a new byte when it is empty or drained this cycle.
  assign in_stall   = valid_r && !consume;
  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

// ===== sv/lpfd_parser.sv =====
// Frame parser of the deframer: header state and the per-byte result logic.
// Depends on lpfd_pkg for phase codes, status codes and the result type.
module lpfd_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_valid,
  input  logic [7:0]    byte_data,
  input  logic          out_free,
  output logic          consume,
  output logic          emit,
  output lpfd_pkg::res_t res
);
  import lpfd_pkg::*;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  size_hi_r, size_hi_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic [7:0]  op_lo_r, op_lo_nxt;
  logic [15:0] opcode_r, opcode_nxt;
  logic        first_r, first_nxt;
  logic        error_r, error_nxt;
  logic        want_emit;
  logic [15:0] size_full;
  logic        last;

  assign size_full = {size_hi_r, byte_data};
  assign last      = (remaining_r <= 16'd1);

  always_comb begin
    phase_nxt     = phase_r;
    size_hi_nxt   = size_hi_r;
    len_nxt       = len_r;
    remaining_nxt = remaining_r;
    op_lo_nxt     = op_lo_r;
    opcode_nxt    = opcode_r;
    first_nxt     = first_r;
    error_nxt     = error_r;
    want_emit     = 1'b0;
    res           = '0;
    if (!error_r) begin
      unique case (phase_r)
        PH_SIZE_HI: begin
          size_hi_nxt = byte_data;
          phase_nxt   = PH_SIZE_LO;
        end
        PH_SIZE_LO: begin
          if (size_full < OPCODE_BYTES) begin
            error_nxt  = 1'b1;
            phase_nxt  = PH_SIZE_HI;
            want_emit  = 1'b1;
            res.status = ST_BADSIZE;
          end else begin
            len_nxt   = size_full - OPCODE_BYTES;
            phase_nxt = PH_OP_LO;
          end
        end
        PH_OP_LO: begin
          op_lo_nxt = byte_data;
          phase_nxt = PH_OP_HI;
        end
        PH_OP_HI: begin
          opcode_nxt    = {byte_data, op_lo_r};
          remaining_nxt = len_r;
          first_nxt     = 1'b1;
          if (len_r == 16'd0) begin
            phase_nxt          = PH_SIZE_HI;
            want_emit          = 1'b1;
            res.status         = ST_EMPTY;
            res.frame_opcode   = {byte_data, op_lo_r};
            res.first_of_frame = 1'b1;
            res.last_of_frame  = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          want_emit          = 1'b1;
          res.status         = ST_PAYLOAD;
          res.frame_opcode   = opcode_r;
          res.payload_byte   = byte_data;
          res.payload_length = len_r;
          res.first_of_frame = first_r;
          res.last_of_frame  = last;
          if (last) begin
            remaining_nxt = 16'd0;
            phase_nxt     = PH_SIZE_HI;
            first_nxt     = 1'b1;
          end else begin
            remaining_nxt = remaining_r - 16'd1;
            first_nxt     = 1'b0;
          end
        end
        default: begin
          phase_nxt = PH_SIZE_HI;
        end
      endcase
    end
  end

  // A byte that makes a result waits until the output register has room.
  assign consume = byte_valid && (!want_emit || out_free);
  assign emit    = consume && want_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIZE_HI;
      size_hi_r   <= 8'd0;
      len_r       <= 16'd0;
      remaining_r <= 16'd0;
      op_lo_r     <= 8'd0;
      opcode_r    <= 16'd0;
      first_r     <= 1'b1;
      error_r     <= 1'b0;
    end else if (consume) begin
      phase_r     <= phase_nxt;
      size_hi_r   <= size_hi_nxt;
      len_r       <= len_nxt;
      remaining_r <= remaining_nxt;
      op_lo_r     <= op_lo_nxt;
      opcode_r    <= opcode_nxt;
      first_r     <= first_nxt;
      error_r     <= error_nxt;
    end
  end

endmodule

// ===== sv/lpfd_out_reg.sv =====
// Output register stage of the deframer: holds one result until it is taken.
// Depends on lpfd_pkg for the result type.
module lpfd_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  lpfd_pkg::res_t res,
  output logic           out_free,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_status,
  output logic [15:0]    out_frame_opcode,
  output logic [7:0]     out_payload_byte,
  output logic [15:0]    out_payload_length,
  output logic           out_first_of_frame,
  output logic           out_last_of_frame
);
  import lpfd_pkg::*;

  logic valid_r;
  res_t res_r;

  // The register has room when it is empty or its result leaves this cycle.
  assign out_free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid          = valid_r;
  assign out_status         = res_r.status;
  assign out_frame_opcode   = res_r.frame_opcode;
  assign out_payload_byte   = res_r.payload_byte;
  assign out_payload_length = res_r.payload_length;
  assign out_first_of_frame = res_r.first_of_frame;
  assign out_last_of_frame  = res_r.last_of_frame;

endmodule
